[design/urcd_pkg.sv]
package urcd_pkg;

    localparam int NUM_SOCKETS     = 8;
    localparam int FIELD_MAX_CHARS = 7;
    localparam int CNT_W           = $clog2(FIELD_MAX_CHARS);

    localparam logic signed [15:0] SOCK_LIMIT = 16'(NUM_SOCKETS);
    localparam logic [15:0]        MALFORMED  = 16'hFC19;   // -999

    // event codes on o_event_kind
    localparam logic [2:0] EV_PAYLOAD   = 3'd0;
    localparam logic [2:0] EV_HEADER    = 3'd1;
    localparam logic [2:0] EV_CHUNK_END = 3'd2;
    localparam logic [2:0] EV_UNHANDLED = 3'd3;
    localparam logic [2:0] EV_BAD_SOCK  = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // "+CIPRCV,"
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h43;
            3'd2:    c = 8'h49;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h52;
            3'd5:    c = 8'h43;
            3'd6:    c = 8'h56;
            default: c = 8'h2C;
        endcase
        return c;
    endfunction

endpackage

[design/at_urc_socket_chunk_demux_unit.sv]
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-------------------------------------------
// rx      | in        | i_in_valid / o_in_ready | i_rx_byte
// event   | out       | o_out_valid / i_out_ready | o_event_kind, o_socket_id,
//         |           |                         | o_chunk_length, o_payload_byte,
//         |           |                         | o_last_of_chunk
//
// One item per cycle: the parser state is updated at the edge that takes the
// byte, and the event (if any) lands in the output register at that same edge.
// o_out_valid is registered and rises in the cycle after the accept.
// o_in_ready drops only while an event sits unclaimed in the output register;
// a byte that makes no event is taken even then only if the register drains.
// Synchronous active-low reset returns the parser to idle with no event held.
module at_urc_socket_chunk_demux_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_event_kind,
    output logic signed [15:0]  o_socket_id,
    output logic signed [15:0]  o_chunk_length,
    output logic [7:0]          o_payload_byte,
    output logic                o_last_of_chunk
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SOCK,
        ST_LEN,
        ST_PAY,
        ST_DISC,
        ST_SKIP
    } t_mode;

    // parser state
    t_mode                          r_mode, n_mode;
    logic [2:0]                     r_match, n_match;
    logic [urcd_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [15:0]                    r_acc, n_acc;
    logic                           r_neg, n_neg;
    logic                           r_stop, n_stop;
    logic [15:0]                    r_cur_sock, n_cur_sock;
    logic [15:0]                    r_remain, n_remain;
    logic [1:0]                     r_line, n_line;
    logic                           r_cr, n_cr;

    // output register
    logic                           r_out_valid;
    logic [2:0]                     r_kind, n_kind;
    logic [15:0]                    r_sock, n_sock;
    logic [15:0]                    r_len, n_len;
    logic [7:0]                     r_byte, n_byte;
    logic                           r_last, n_last;
    logic                           n_emit;

    // field parser terms
    logic                           w_accept;
    logic [7:0]                     w_term;
    logic                           w_hit_term;
    logic                           w_digit;
    logic [15:0]                    w_acc_step;
    logic [urcd_pkg::CNT_W:0]       w_cnt_inc;
    logic                           w_fdone;
    logic [15:0]                    w_fvalue;
    logic                           w_bad_sock;
    logic                           w_pay_last;
    logic [3:0]                     w_match_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_term     = (r_mode == ST_LEN) ? urcd_pkg::CH_COLON : urcd_pkg::CH_COMMA;
    assign w_hit_term = (i_rx_byte == w_term);
    assign w_digit    = (i_rx_byte >= urcd_pkg::CH_ZERO) && (i_rx_byte <= urcd_pkg::CH_NINE);
    // acc * 10 + digit, wraps at 16 bits
    assign w_acc_step = (r_acc << 3) + (r_acc << 1) + {12'd0, i_rx_byte[3:0]};
    assign w_cnt_inc  = {1'b0, r_cnt} + 1'b1;
    assign w_fdone    = w_hit_term || (w_cnt_inc >= (urcd_pkg::CNT_W+1)'(urcd_pkg::FIELD_MAX_CHARS));

    always_comb begin
        if (!w_hit_term || r_cnt == '0) begin
            w_fvalue = urcd_pkg::MALFORMED;
        end else if (r_neg) begin
            w_fvalue = 16'd0 - r_acc;
        end else begin
            w_fvalue = r_acc;
        end
    end

    assign w_bad_sock  = ($signed(r_cur_sock) < 0) || ($signed(r_cur_sock) >= urcd_pkg::SOCK_LIMIT);
    assign w_pay_last  = ($signed(r_remain) <= 16'sd1);
    assign w_match_inc = {1'b0, r_match} + 1'b1;

    always_comb begin
        n_mode     = r_mode;
        n_match    = r_match;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_stop     = r_stop;
        n_cur_sock = r_cur_sock;
        n_remain   = r_remain;
        n_line     = r_line;
        n_cr       = r_cr;
        n_emit     = 1'b0;
        n_kind     = urcd_pkg::EV_PAYLOAD;
        n_sock     = 16'd0;
        n_len      = 16'd0;
        n_byte     = 8'd0;
        n_last     = 1'b0;

        case (r_mode)
            ST_SOCK, ST_LEN: begin
                if (w_fdone) begin
                    n_cnt  = '0;
                    n_acc  = 16'd0;
                    n_neg  = 1'b0;
                    n_stop = 1'b0;
                end else begin
                    n_cnt = w_cnt_inc[urcd_pkg::CNT_W-1:0];
                    if (r_cnt == '0 && i_rx_byte == urcd_pkg::CH_MINUS) begin
                        n_neg = 1'b1;
                    end else if (!r_stop && w_digit) begin
                        n_acc = w_acc_step;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                if (w_fdone) begin
                    if (r_mode == ST_SOCK) begin
                        n_cur_sock = w_fvalue;
                        n_mode     = ST_LEN;
                    end else begin
                        n_remain = w_fvalue;
                        n_emit   = 1'b1;
                        n_sock   = r_cur_sock;
                        n_len    = w_fvalue;
                        if (w_bad_sock) begin
                            n_mode = ST_DISC;
                            n_kind = urcd_pkg::EV_BAD_SOCK;
                        end else begin
                            n_mode = ST_PAY;
                            n_kind = urcd_pkg::EV_HEADER;
                        end
                    end
                end
            end
            ST_PAY, ST_DISC: begin
                n_remain = r_remain - 16'd1;
                if (w_pay_last) begin
                    n_mode = ST_SKIP;
                end
                if (r_mode == ST_PAY) begin
                    n_emit = 1'b1;
                    n_kind = urcd_pkg::EV_PAYLOAD;
                    n_sock = r_cur_sock;
                    n_byte = i_rx_byte;
                    n_last = w_pay_last;
                end
            end
            ST_SKIP: begin
                if (i_rx_byte == urcd_pkg::CH_LF) begin
                    n_mode = ST_IDLE;
                    n_emit = 1'b1;
                    n_kind = urcd_pkg::EV_CHUNK_END;
                    n_sock = r_cur_sock;
                end
            end
            default: begin
                // idle: hunt for the header, watch for CRLF line ends
                n_mode = ST_IDLE;
                n_line = (r_line == 2'd3) ? 2'd3 : r_line + 2'd1;
                if (i_rx_byte == urcd_pkg::hdr_char(r_match) && w_match_inc == 4'd8) begin
                    n_match = 3'd0;
                    n_line  = 2'd0;
                    n_cr    = 1'b0;
                    n_cnt   = '0;
                    n_acc   = 16'd0;
                    n_neg   = 1'b0;
                    n_stop  = 1'b0;
                    n_mode  = ST_SOCK;
                end else begin
                    if (i_rx_byte == urcd_pkg::hdr_char(r_match)) begin
                        n_match = w_match_inc[2:0];
                    end else begin
                        n_match = (i_rx_byte == urcd_pkg::CH_PLUS) ? 3'd1 : 3'd0;
                    end
                    if (i_rx_byte == urcd_pkg::CH_LF && r_cr && n_line == 2'd3) begin
                        n_match = 3'd0;
                        n_line  = 2'd0;
                        n_cr    = 1'b0;
                        n_emit  = 1'b1;
                        n_kind  = urcd_pkg::EV_UNHANDLED;
                    end else begin
                        n_cr = (i_rx_byte == urcd_pkg::CH_CR);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_IDLE;
            r_match     <= 3'd0;
            r_cnt       <= '0;
            r_acc       <= 16'd0;
            r_neg       <= 1'b0;
            r_stop      <= 1'b0;
            r_cur_sock  <= 16'd0;
            r_remain    <= 16'd0;
            r_line      <= 2'd0;
            r_cr        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mode      <= n_mode;
                r_match     <= n_match;
                r_cnt       <= n_cnt;
                r_acc       <= n_acc;
                r_neg       <= n_neg;
                r_stop      <= n_stop;
                r_cur_sock  <= n_cur_sock;
                r_remain    <= n_remain;
                r_line      <= n_line;
                r_cr        <= n_cr;
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // event payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_kind <= n_kind;
            r_sock <= n_sock;
            r_len  <= n_len;
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_kind;
    assign o_socket_id     = $signed(r_sock);
    assign o_chunk_length  = $signed(r_len);
    assign o_payload_byte  = r_byte;
    assign o_last_of_chunk = r_last;

    // a payload byte accepted in forward mode always yields a payload event
    a_pay_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == ST_PAY) |=>
            (o_out_valid && o_event_kind == urcd_pkg::EV_PAYLOAD))
        else $error("payload byte produced no payload event");

    // last flag only on payload events
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_chunk) |-> (o_event_kind == urcd_pkg::EV_PAYLOAD))
        else $error("last_of_chunk on non-payload event");

    // a rejected socket sends the parser to silent discard
    a_bad_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == ST_LEN && n_mode == ST_DISC) |=>
            (r_mode == ST_DISC && o_out_valid && o_event_kind == urcd_pkg::EV_BAD_SOCK))
        else $error("bad socket not reported or discard not entered");

    // discard mode never forwards bytes
    a_disc_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == ST_DISC) |=> !o_out_valid)
        else $error("event raised while discarding");

endmodule
